// ----- rtl/core/msxbm_pkg.sv -----
package msxbm_pkg;

   // page table geometry
   localparam int unsigned PAGE_COUNT = 8;
   localparam int unsigned PAGE_BITS  = 3;
   localparam int unsigned OFFS_BITS  = 13;
   localparam int unsigned SEG_BITS   = 9;
   localparam int unsigned PHYS_BITS  = 22;

   // configuration register indexes
   localparam logic [1:0] CSR_MAPPER_MODE = 2'd0;
   localparam logic [1:0] CSR_ROM_SEGS    = 2'd1;
   localparam logic [1:0] CSR_RAM_SEGS    = 2'd2;

   // mapper modes
   localparam logic [2:0] MODE_ROM      = 3'd0;
   localparam logic [2:0] MODE_ROM32K   = 3'd1;
   localparam logic [2:0] MODE_KONAMI   = 3'd2;
   localparam logic [2:0] MODE_KONAMI_Z = 3'd3;
   localparam logic [2:0] MODE_ASCII8   = 3'd4;
   localparam logic [2:0] MODE_ASCII16  = 3'd5;
   localparam logic [2:0] MODE_RAM      = 3'd6;

   // result register occupancy
   typedef enum logic {
      ST_EMPTY,
      ST_FULL
   } ctrl_state_type;

   // controller to datapath commands
   typedef struct packed {
      logic capture;   // access beat accepted, translate and register result
      logic csr_write; // configuration beat accepted
   } dp_cmd_type;

endpackage

// ----- rtl/core/msx_cartridge_bank_mapper_unit.sv -----
// MSX cartridge bank mapper: each request beat is one bus access (read or write,
// 16-bit address, data byte) and yields one response beat with the page's mapped
// flag, ROM/RAM target, 22-bit physical offset, RAM write strobe and bank switch
// flag. One access is taken per clock unless stalled by rsp_ready; the registered
// response appears in the cycle after the request beat, and a new request is taken
// in the same cycle as the pending response is taken. Rate is set by the single
// read and update of the eight-entry page table per access. Mapped flag and offset
// reflect the table before the access's own bank switch. Writing the mode register
// (index 0) reloads the whole table using the segment counts (indexes 1 and 2)
// as last written; configure only while no access is pending.
module msx_cartridge_bank_mapper_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [3:0]  csr_write_data,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_type,
   input  logic [15:0] req_bus_address,
   input  logic [7:0]  req_write_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_is_mapped,
   output logic        rsp_to_ram,
   output logic [21:0] rsp_physical_offset,
   output logic        rsp_ram_write_strobe,
   output logic        rsp_bank_switched
);
   import msxbm_pkg::*;

   dp_cmd_type cmd;

   // handshake control
   msxbm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .cmd       (cmd)
   );

   // page table, config and result registers
   msxbm_datapath u_datapath (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .csr_index            (csr_index),
      .csr_write_data       (csr_write_data),
      .req_type             (req_type),
      .req_bus_address      (req_bus_address),
      .req_write_data       (req_write_data),
      .rsp_is_mapped        (rsp_is_mapped),
      .rsp_to_ram           (rsp_to_ram),
      .rsp_physical_offset  (rsp_physical_offset),
      .rsp_ram_write_strobe (rsp_ram_write_strobe),
      .rsp_bank_switched    (rsp_bank_switched)
   );

endmodule

// ----- rtl/core/msxbm_ctrl.sv -----
module msxbm_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   input  logic                csr_valid,
   output logic                csr_ready,
   output msxbm_pkg::dp_cmd_type cmd
);
   import msxbm_pkg::*;

   ctrl_state_type state_ff;
   ctrl_state_type state_in;
   logic           req_fire;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_EMPTY;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and handshake outputs
   always_comb begin
      req_ready     = (state_ff == ST_EMPTY) || rsp_ready;
      req_fire      = req_valid && req_ready;
      rsp_valid     = (state_ff == ST_FULL);
      csr_ready     = 1'b1;
      cmd.capture   = req_fire;
      cmd.csr_write = csr_valid;
      state_in      = state_ff;
      case (state_ff)
         ST_EMPTY: begin
            if (req_fire) begin
               state_in = ST_FULL;
            end
         end
         ST_FULL: begin
            if (rsp_ready && !req_fire) begin
               state_in = ST_EMPTY;
            end
         end
         default: begin
            state_in = ST_EMPTY;
         end
      endcase
   end

endmodule

// ----- rtl/core/msxbm_datapath.sv -----
module msxbm_datapath (
   input  logic                  clock,
   input  logic                  reset,
   input  msxbm_pkg::dp_cmd_type cmd,
   input  logic [1:0]            csr_index,
   input  logic [3:0]            csr_write_data,
   input  logic                  req_type,
   input  logic [15:0]           req_bus_address,
   input  logic [7:0]            req_write_data,
   output logic                  rsp_is_mapped,
   output logic                  rsp_to_ram,
   output logic [21:0]           rsp_physical_offset,
   output logic                  rsp_ram_write_strobe,
   output logic                  rsp_bank_switched
);
   import msxbm_pkg::*;

   typedef struct packed {
      logic                valid;
      logic [SEG_BITS-1:0] seg;
   } page_entry_type;

   // initial mapping of one page for a given mode
   function automatic page_entry_type init_entry(input logic [2:0] mode,
                                                 input logic [PAGE_BITS-1:0] page,
                                                 input logic [3:0] rc,
                                                 input logic [3:0] mc);
      page_entry_type e;
      logic [3:0]     r;
      e.valid = 1'b0;
      e.seg   = '0;
      // page mod rom count, rc is 1..8 so seven subtracts at most
      r = {1'b0, page};
      for (int k = 0; k < PAGE_COUNT - 1; k++) begin
         if (r >= rc) begin
            r = r - rc;
         end
      end
      case (mode)
         MODE_ROM: begin
            e.valid = 1'b1;
            e.seg   = {{(SEG_BITS-4){1'b0}}, r};
         end
         MODE_ROM32K: begin
            e.valid = 1'b1;
            e.seg   = {{(SEG_BITS-2){1'b0}}, page[1:0] + 2'd2};
         end
         MODE_KONAMI, MODE_KONAMI_Z: begin
            if (page inside {[3'd2:3'd5]}) begin
               e.valid = 1'b1;
               e.seg   = {{(SEG_BITS-PAGE_BITS){1'b0}}, page - 3'd2};
            end
         end
         MODE_ASCII8: begin
            e.valid = 1'b1;
         end
         MODE_ASCII16: begin
            e.valid = 1'b1;
            e.seg   = {{(SEG_BITS-1){1'b0}}, page[0]};
         end
         MODE_RAM: begin
            if ({1'b0, page} < mc) begin
               e.valid = 1'b1;
               e.seg   = {{(SEG_BITS-PAGE_BITS){1'b0}}, page};
            end
         end
         default: begin
            e.valid = 1'b0;
         end
      endcase
      return e;
   endfunction

   logic [2:0]     mode_ff;
   logic [3:0]     rom_segs_ff;
   logic [3:0]     ram_segs_ff;
   page_entry_type table_ff [PAGE_COUNT];
   page_entry_type table_in [PAGE_COUNT];

   logic                 is_mapped_ff;
   logic                 to_ram_ff;
   logic [PHYS_BITS-1:0] phys_ff;
   logic                 strobe_ff;
   logic                 switched_ff;

   logic [PAGE_BITS-1:0] page;
   page_entry_type       cur;
   logic                 mapped;
   logic                 ram;
   logic [PHYS_BITS-1:0] phys;
   logic                 strobe;
   logic                 switched;
   logic                 reload;
   logic [3:0]           rc_clamp;
   logic [3:0]           mc_clamp;
   logic [SEG_BITS-1:0]  data_seg;
   logic [PAGE_BITS-1:0] a8_page;
   logic [PAGE_BITS-1:0] a16_lo;
   logic [PAGE_BITS-1:0] a16_hi;

   // translation of the current access through the table
   always_comb begin
      page   = req_bus_address[15:13];
      cur    = table_ff[page];
      mapped = cur.valid;
      ram    = mapped && (mode_ff == MODE_RAM);
      phys   = mapped ? {cur.seg, req_bus_address[OFFS_BITS-1:0]} : '0;
   end

   // bank switch targets
   always_comb begin
      data_seg = {1'b0, req_write_data};
      a8_page  = 3'd2 + {1'b0, req_bus_address[12:11]};
      a16_lo   = {req_bus_address[12], ~req_bus_address[12], 1'b0};
      a16_hi   = {req_bus_address[12], ~req_bus_address[12], 1'b1};
      rc_clamp = (rom_segs_ff == 4'd0) ? 4'd1 : ((rom_segs_ff > 4'd8) ? 4'd8 : rom_segs_ff);
      mc_clamp = (ram_segs_ff > 4'd8) ? 4'd8 : ram_segs_ff;
      reload   = cmd.csr_write && (csr_index == CSR_MAPPER_MODE);
   end

   // page table next value: mode reload or bank switch write
   always_comb begin
      strobe   = 1'b0;
      switched = 1'b0;
      for (int i = 0; i < PAGE_COUNT; i++) begin
         table_in[i] = table_ff[i];
      end
      if (reload) begin
         for (int i = 0; i < PAGE_COUNT; i++) begin
            table_in[i] = init_entry(csr_write_data[2:0], PAGE_BITS'(i), rc_clamp, mc_clamp);
         end
      end else if (cmd.capture && req_type) begin
         if (mode_ff == MODE_RAM) begin
            strobe = mapped;
         end else if (mode_ff == MODE_KONAMI && (page inside {[3'd2:3'd5]})) begin
            table_in[page] = '{valid: 1'b1, seg: data_seg};
            switched       = 1'b1;
         end else if (mode_ff == MODE_KONAMI_Z && (page inside {3'd4, 3'd5})) begin
            table_in[page] = '{valid: 1'b1, seg: data_seg};
            switched       = 1'b1;
         end else if (mode_ff == MODE_ASCII8 && page == 3'd3) begin
            table_in[a8_page] = '{valid: 1'b1, seg: data_seg};
            switched          = 1'b1;
         end else if (mode_ff == MODE_ASCII16 && page == 3'd3) begin
            table_in[a16_lo] = '{valid: 1'b1, seg: {req_write_data, 1'b0}};
            table_in[a16_hi] = '{valid: 1'b1, seg: {req_write_data, 1'b1}};
            switched         = 1'b1;
         end
      end
   end

   // configuration registers and page table
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= MODE_ROM;
         rom_segs_ff <= 4'd8;
         ram_segs_ff <= 4'd8;
         for (int i = 0; i < PAGE_COUNT; i++) begin
            table_ff[i] <= '{valid: 1'b1, seg: SEG_BITS'(i)};
         end
      end else begin
         if (cmd.csr_write) begin
            case (csr_index)
               CSR_MAPPER_MODE: mode_ff     <= csr_write_data[2:0];
               CSR_ROM_SEGS:    rom_segs_ff <= csr_write_data;
               CSR_RAM_SEGS:    ram_segs_ff <= csr_write_data;
               default:         mode_ff     <= mode_ff;
            endcase
         end
         for (int i = 0; i < PAGE_COUNT; i++) begin
            table_ff[i] <= table_in[i];
         end
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         is_mapped_ff <= mapped;
         to_ram_ff    <= ram;
         phys_ff      <= phys;
         strobe_ff    <= strobe;
         switched_ff  <= switched;
      end
   end

   assign rsp_is_mapped        = is_mapped_ff;
   assign rsp_to_ram           = to_ram_ff;
   assign rsp_physical_offset  = phys_ff;
   assign rsp_ram_write_strobe = strobe_ff;
   assign rsp_bank_switched    = switched_ff;

endmodule
